// File: sv/thruster_on_time_step_timer_defines.svh
// ----------------------------------------------------------------------------
// thruster on-time step timer assertion macros
// shared concurrent assertion forms, clocked on clk with reset rst_n
// ----------------------------------------------------------------------------
`ifndef THRUSTER_ON_TIME_STEP_TIMER_DEFINES_SVH
`define THRUSTER_ON_TIME_STEP_TIMER_DEFINES_SVH

// property that must hold at every edge outside reset
`define TOTS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// implication property, antecedent and consequent given as one property expression
`define TOTS_ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// File: sv/tots_pkg.sv
// ----------------------------------------------------------------------------
// tots_pkg
// types and constants of the thruster on-time step timer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tots_pkg;

    localparam int CHANNELS   = 2;
    localparam int DATA_W     = 32;
    // numerator 2t+s needs two bits above the field width
    localparam int NUM_W      = DATA_W + 2;
    localparam int DEN_W      = DATA_W + 1;
    localparam int DIV_STEPS  = NUM_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 2;

    localparam logic [DATA_W-1:0] TIME_STEP_RESET = 32'd655;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP = 2'd0,
        REG_FORCE_A   = 2'd1,
        REG_FORCE_B   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIRE
    } state_t;

    typedef struct packed {
        logic              new_command;
        logic [DATA_W-1:0] on_time_a;
        logic [DATA_W-1:0] on_time_b;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] thrust_a;
        logic [DATA_W-1:0] thrust_b;
    } out_item_t;

endpackage

// File: sv/thruster_on_time_step_timer.sv
// ----------------------------------------------------------------------------
// thruster on-time step timer
// two-channel firing timer: on-time over tick period, rounded half up,
// counted down one step per control tick
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | sink      | in_valid / in_ready   | in_data (tots_pkg::in_item_t)
//  out     | source    | out_valid / out_ready | out_data (tots_pkg::out_item_t)
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  a tick without a command: result registered at the accepting edge
//  a command tick: the bit-serial restoring divider in S_DIV makes one quotient bit
//  per cycle (both channels side by side), then S_FIRE loads the step counters
//  in_ready waits for S_IDLE and for the output register to be free or being emptied
//  rst_n clears the step counters, the state and time_step back to 0.01 s
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "thruster_on_time_step_timer_defines.svh"

module thruster_on_time_step_timer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  tots_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output tots_pkg::out_item_t                  out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tots_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tots_pkg::DATA_W-1:0]          cfg_data
);

    import tots_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DATA_W-1:0]   time_step_reg, time_step_next;
    logic [DATA_W-1:0]   force_reg [CHANNELS];
    logic [DATA_W-1:0]   force_next [CHANNELS];
    logic [DATA_W-1:0]   remain_reg [CHANNELS];
    logic [DATA_W-1:0]   remain_next [CHANNELS];
    // numerator shifts out at the top while quotient bits shift in below
    logic [NUM_W-1:0]    nq_reg [CHANNELS];
    logic [NUM_W-1:0]    nq_next [CHANNELS];
    logic [DEN_W-1:0]    rem_reg [CHANNELS];
    logic [DEN_W-1:0]    rem_next [CHANNELS];
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            time_step_reg <= TIME_STEP_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                force_reg[i]  <= '0;
                remain_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            time_step_reg <= time_step_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < CHANNELS; i++)
            begin
                force_reg[i]  <= force_next[i];
                remain_reg[i] <= remain_next[i];
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        for (int i = 0; i < CHANNELS; i++)
        begin
            nq_reg[i]  <= nq_next[i];
            rem_reg[i] <= rem_next[i];
        end
    end

    always_comb
    begin
        logic [DATA_W-1:0] on_time [CHANNELS];
        logic [DATA_W-1:0] thrust  [CHANNELS];
        logic [DATA_W-1:0] steps   [CHANNELS];
        logic [NUM_W-1:0]  trial   [CHANNELS];
        logic [NUM_W-1:0]  diff    [CHANNELS];
        logic [DEN_W-1:0]  den;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        time_step_next = time_step_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        on_time[0]     = in_data.on_time_a;
        on_time[1]     = in_data.on_time_b;
        den            = {time_step_reg, 1'b0};
        for (int i = 0; i < CHANNELS; i++)
        begin
            force_next[i]  = force_reg[i];
            remain_next[i] = remain_reg[i];
            nq_next[i]     = nq_reg[i];
            rem_next[i]    = rem_reg[i];
            thrust[i]      = '0;
            steps[i]       = remain_reg[i];
            trial[i]       = {rem_reg[i], nq_reg[i][NUM_W-1]};
            diff[i]        = trial[i] - {1'b0, den};
        end

        in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (in_data.new_command)
                    begin
                        for (int i = 0; i < CHANNELS; i++)
                        begin
                            nq_next[i]  = {1'b0, on_time[i], 1'b0} + {2'b00, time_step_reg};
                            rem_next[i] = '0;
                        end
                        cnt_next   = '0;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        for (int i = 0; i < CHANNELS; i++)
                        begin
                            if (steps[i] != '0)
                            begin
                                thrust[i]      = force_reg[i];
                                remain_next[i] = steps[i] - 1'b1;
                            end
                        end
                        out_data_next.thrust_a = thrust[0];
                        out_data_next.thrust_b = thrust[1];
                        out_valid_next         = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                // one restoring step per cycle in each lane
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (!diff[i][NUM_W-1])
                    begin
                        rem_next[i] = diff[i][DEN_W-1:0];
                        nq_next[i]  = {nq_reg[i][NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[i] = trial[i][DEN_W-1:0];
                        nq_next[i]  = {nq_reg[i][NUM_W-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIRE;
                end
            end
            S_FIRE:
            begin
                // quotient never exceeds 32 bits since time_step is non-zero
                for (int i = 0; i < CHANNELS; i++)
                begin
                    steps[i]       = nq_reg[i][DATA_W-1:0];
                    remain_next[i] = steps[i];
                    if (steps[i] != '0)
                    begin
                        thrust[i]      = force_reg[i];
                        remain_next[i] = steps[i] - 1'b1;
                    end
                end
                out_data_next.thrust_a = thrust[0];
                out_data_next.thrust_b = thrust[1];
                out_valid_next         = 1'b1;
                state_next             = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TIME_STEP:
                begin
                    if (cfg_data != '0)
                    begin
                        time_step_next = cfg_data;
                    end
                end
                REG_FORCE_A: force_next[0] = cfg_data;
                REG_FORCE_B: force_next[1] = cfg_data;
                default:     ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `TOTS_ASSERT_ALWAYS(a_time_step_nonzero, time_step_reg != '0, "time_step register is zero")
    `TOTS_ASSERT_IMPL(a_ready_only_idle, (in_ready |-> state_reg == S_IDLE), "ready while busy")
    `TOTS_ASSERT_IMPL(a_no_result_in_div, (state_reg == S_DIV |-> !out_valid_reg), "result held during division")
    `TOTS_ASSERT_IMPL(a_plain_tick_result, (in_valid && in_ready && !in_data.new_command |=> out_valid_reg), "plain tick gave no result")
    `TOTS_ASSERT_IMPL(a_fire_returns_idle, (state_reg == S_FIRE |=> state_reg == S_IDLE && out_valid_reg), "fire step did not complete")

endmodule

// File: tb/thruster_on_time_step_timer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thruster on-time step timer testbench
// drives control ticks through the valid/ready input channel, predicts each
// tick's thrust pair from a local copy of the step targets and fired counts,
// and checks every result in order; register settings change between phases
// ----------------------------------------------------------------------------

module thruster_on_time_step_timer_test;

    import tots_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int PRINT_CAP      = 40;
    localparam int PHASES         = 6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;

    // ticks waiting to be offered, thrust pairs waiting to come out
    in_item_t  tick_queue [$];
    out_item_t thrust_due [$];

    // timer state as the block should hold it
    logic [DATA_W-1:0] tick_period = TIME_STEP_RESET;
    logic [DATA_W-1:0] thrust_level [CHANNELS] = '{default: '0};
    logic [DATA_W-1:0] step_target  [CHANNELS] = '{default: '0};
    logic [DATA_W-1:0] steps_fired  [CHANNELS] = '{default: '0};

    logic [DATA_W-1:0] plan_step = TIME_STEP_RESET;
    int unsigned idle_pct     = 24;
    int          holdoff_goal = 0;
    int          holdoff_done = 0;
    int          holdoff_left = 0;
    int          in_sent_cnt  = 0;
    int          in_acc_cnt   = 0;
    int          cycle_cnt    = 0;
    int          fail_cnt     = 0;
    int          cmd_cnt      = 0;
    int          result_cnt   = 0;
    int          firing_cnt   = 0;
    out_item_t   want;

    thruster_on_time_step_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (fail_cnt < PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        fail_cnt++;
    endtask

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [DATA_W-1:0] val);
        case (cfg_reg_t'(idx))
            REG_TIME_STEP:
                if (val != '0)
                    tick_period = val;
            REG_FORCE_A:   thrust_level[0] = val;
            REG_FORCE_B:   thrust_level[1] = val;
            default:       ;
        endcase
    endfunction

    // one control tick: reload targets on a command, then fire while below target
    function automatic out_item_t advance_timer(input in_item_t tick);
        logic [63:0]       num;
        logic [63:0]       den;
        logic [63:0]       quo;
        logic [DATA_W-1:0] on_t;
        logic [DATA_W-1:0] level [CHANNELS];
        out_item_t         res;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if (tick.new_command)
            begin
                on_t = (ch == 0) ? tick.on_time_a : tick.on_time_b;
                // round half up: floor((2t + s) / 2s)
                num = 2 * 64'(on_t) + 64'(tick_period);
                den = 2 * 64'(tick_period);
                quo = num / den;
                step_target[ch] = (quo > 64'hFFFF_FFFF) ? '1 : quo[DATA_W-1:0];
                steps_fired[ch] = '0;
            end
            if (steps_fired[ch] < step_target[ch])
            begin
                level[ch] = thrust_level[ch];
                steps_fired[ch] = steps_fired[ch] + 1;
            end
            else
                level[ch] = '0;
        end
        res.thrust_a = level[0];
        res.thrust_b = level[1];
        return res;
    endfunction

    // tick driver
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && in_acc_cnt != in_sent_cnt))
        begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                in_data     <= tick_queue.pop_front();
                in_valid    <= 1'b1;
                in_sent_cnt <= in_sent_cnt + 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
            out_ready    <= 1'b0;
        end
        else if (holdoff_done != holdoff_goal)
        begin
            holdoff_done <= holdoff_goal;
            holdoff_left <= HOLDOFF_CYCLES;
            out_ready    <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // monitor and checker
    always @(posedge clk)
    begin
        cycle_cnt = cycle_cnt + 1;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_reg_write(cfg_index, cfg_data);
            // a result leaving now belongs to an earlier tick, so check before predicting
            if (out_valid && out_ready)
            begin
                result_cnt++;
                if (out_data.thrust_a != '0 || out_data.thrust_b != '0)
                    firing_cnt++;
                if (thrust_due.size() == 0)
                    report_mismatch($sformatf("result %h with no tick waiting", out_data));
                else
                begin
                    want = thrust_due.pop_front();
                    if (out_data.thrust_a !== want.thrust_a)
                        report_mismatch($sformatf("thrust_a got %h want %h",
                                                  out_data.thrust_a, want.thrust_a));
                    if (out_data.thrust_b !== want.thrust_b)
                        report_mismatch($sformatf("thrust_b got %h want %h",
                                                  out_data.thrust_b, want.thrust_b));
                end
            end
            if (in_valid && in_ready)
            begin
                if (in_data.new_command)
                    cmd_cnt++;
                thrust_due.push_back(advance_timer(in_data));
                in_acc_cnt <= in_acc_cnt + 1;
            end
        end
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, thrust_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [DATA_W-1:0] step, input logic [DATA_W-1:0] fa,
                              input logic [DATA_W-1:0] fb);
        write_reg(REG_TIME_STEP, step);
        write_reg(REG_FORCE_A, fa);
        write_reg(REG_FORCE_B, fb);
        if (step != '0)
            plan_step = step;
    endtask

    task automatic push_tick(input logic cmd, input logic [DATA_W-1:0] a,
                             input logic [DATA_W-1:0] b);
        in_item_t item;
        item.new_command = cmd;
        item.on_time_a   = a;
        item.on_time_b   = b;
        tick_queue.push_back(item);
    endtask

    // mostly on-times a few steps long, landing on either side of the rounding point
    function automatic logic [DATA_W-1:0] on_time_for(input logic [DATA_W-1:0] step);
        logic [63:0] t;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 60)
        begin
            t = 64'(step) * $urandom_range(12);
            case ($urandom_range(2))
                0:       t += step >> 1;
                1:       t += (64'(step) + 1) >> 1;
                default: t += $urandom % step;
            endcase
            if (t > 64'hFFFF_FFFF)
                t = {32'd0, $urandom};
            return t[DATA_W-1:0];
        end
        else if (sel < 70)
            return '0;
        else if (sel < 80)
            return '1;
        return $urandom;
    endfunction

    task automatic queue_ticks(input int count);
        int unsigned sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 20)
                push_tick(1'b1, on_time_for(plan_step), on_time_for(plan_step));
            else if (sel < 90)
                push_tick(1'b0, $urandom, $urandom);
            else
                push_tick(1'($urandom_range(1)), $urandom, $urandom);
        end
    endtask

    // sender holds back until the last expected result is in
    task automatic wait_drained();
        while (tick_queue.size() != 0 || in_valid || thrust_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values: forces are zero, so every thrust that comes out should be zero
        push_tick(1'b1, 32'd1965, 32'hFFFF_FFFF);
        push_tick(1'b0, 32'd0, 32'd0);
        push_tick(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();

        set_timing(32'd1000, 32'hFFFF_FFFF, 32'h0001_0000);
        push_tick(1'b1, 32'd500, 32'd499);              // exact half rounds up, just below does not
        push_tick(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // on-times ignored without a command
        push_tick(1'b0, 32'd0, 32'd0);
        push_tick(1'b1, 32'd0, 32'd3000);
        for (int i = 0; i < 3; i++)
            push_tick(1'b0, $urandom, $urandom);
        push_tick(1'b1, 32'd5000, 32'hFFFF_FFFF);
        push_tick(1'b0, $urandom, $urandom);
        push_tick(1'b1, 32'd1500, 32'd2499);            // new command while still firing
        for (int i = 0; i < 3; i++)
            push_tick(1'b0, $urandom, $urandom);
        wait_drained();

        // zero period and out-of-range index must both be dropped
        write_reg(REG_TIME_STEP, 32'd0);
        write_reg(REG_UNUSED, $urandom);
        push_tick(1'b1, 32'd1500, 32'd500);
        push_tick(1'b0, 32'd0, 32'd0);
        wait_drained();

        set_timing(32'd1, 32'd0, 32'hFFFF_FFFF);
        push_tick(1'b1, 32'hFFFF_FFFF, 32'd0);
        push_tick(1'b0, $urandom, $urandom);
        push_tick(1'b0, $urandom, $urandom);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            idle_pct = 24;
            case (p)
                0: set_timing(32'd1, $urandom, $urandom);
                1:
                begin
                    set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
                    idle_pct = 0;
                end
                2: set_timing(TIME_STEP_RESET, 32'd0, 32'hFFFF_FFFF);
                3: set_timing($urandom_range(5000, 2), $urandom, $urandom);
                4: set_timing($urandom_range(32'hFFFF_FFFF, 1), $urandom, $urandom);
                default: set_timing(32'd2, $urandom, $urandom);
            endcase
            // receiver stalls long enough for the input side to back up
            if (p == 2)
                holdoff_goal++;
            queue_ticks(95);
            wait_drained();
            queue_ticks(95);
            wait_drained();
        end

        $display("covered %0d ticks with %0d commands over %0d register settings",
                 in_acc_cnt, cmd_cnt, PHASES + 3);
        $display("checked %0d thrust results, %0d with a thruster firing, %0d mismatches",
                 result_cnt, firing_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/tots_pkg.sv
sv/thruster_on_time_step_timer.sv
tb/thruster_on_time_step_timer_test.sv
